/* hdl/mke_pkg.sv */
// Shared types, constants and the Morse code table for the Morse keyer encoder.
package mke_pkg;

   localparam int MKE_QUEUE_DEPTH = 4;
   localparam int MKE_MAX_ELEMS   = 6;
   localparam int MKE_LEN_W       = 3;
   localparam int MKE_CSR_IDX_W   = 3;

   localparam logic [6:0] SYM_DOT   = 7'h2E;
   localparam logic [6:0] SYM_DASH  = 7'h2D;
   localparam logic [6:0] SYM_SPACE = 7'h20;

   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHR_CASE    = 8'h20;

   localparam logic [15:0] SPACE_FREQ_HZ = 16'd1;

   localparam logic [MKE_CSR_IDX_W-1:0] CSR_DOT_MS      = 3'd0;
   localparam logic [MKE_CSR_IDX_W-1:0] CSR_DASH_MS     = 3'd1;
   localparam logic [MKE_CSR_IDX_W-1:0] CSR_GAP_MS      = 3'd2;
   localparam logic [MKE_CSR_IDX_W-1:0] CSR_END_MS      = 3'd3;
   localparam logic [MKE_CSR_IDX_W-1:0] CSR_TONE_HZ     = 3'd4;
   localparam logic [MKE_CSR_IDX_W-1:0] CSR_OUTPUT_MODE = 3'd5;

   localparam logic [15:0] RST_DOT_MS  = 16'd60;
   localparam logic [15:0] RST_DASH_MS = 16'd120;
   localparam logic [15:0] RST_GAP_MS  = 16'd100;
   localparam logic [15:0] RST_END_MS  = 16'd500;
   localparam logic [15:0] RST_TONE_HZ = 16'd1000;

   typedef enum logic {
      MODE_TONE = 1'b0,
      MODE_TEXT = 1'b1
   } mke_mode_type;

   typedef struct packed {
      logic [15:0]  dot_ms;
      logic [15:0]  dash_ms;
      logic [15:0]  gap_ms;
      logic [15:0]  end_ms;
      logic [15:0]  tone_hz;
      mke_mode_type mode;
   } mke_cfg_type;

   // Pattern is left aligned: the first element sits in bit 5, a one is a dash.
   typedef struct packed {
      logic                 is_space;
      logic [MKE_LEN_W-1:0] len;
      logic [5:0]           pattern;
   } mke_entry_type;

   typedef struct packed {
      logic [MKE_LEN_W-1:0] len;
      logic [5:0]           pattern;
   } mke_code_type;

   function automatic mke_code_type mke_lookup(input logic [6:0] chr);
      mke_code_type c;
      case (chr)
         7'd33:   c = '{3'd6, 6'b101011};
         7'd34:   c = '{3'd6, 6'b010010};
         7'd39:   c = '{3'd6, 6'b011110};
         7'd40:   c = '{3'd5, 6'b101100};
         7'd41:   c = '{3'd6, 6'b101101};
         7'd44:   c = '{3'd6, 6'b110011};
         7'd45:   c = '{3'd6, 6'b100001};
         7'd46:   c = '{3'd6, 6'b010101};
         7'd47:   c = '{3'd5, 6'b100100};
         7'd48:   c = '{3'd5, 6'b111110};
         7'd49:   c = '{3'd5, 6'b011110};
         7'd50:   c = '{3'd5, 6'b001110};
         7'd51:   c = '{3'd5, 6'b000110};
         7'd52:   c = '{3'd5, 6'b000010};
         7'd53:   c = '{3'd5, 6'b000000};
         7'd54:   c = '{3'd5, 6'b100000};
         7'd55:   c = '{3'd5, 6'b110000};
         7'd56:   c = '{3'd5, 6'b111000};
         7'd57:   c = '{3'd5, 6'b111100};
         7'd58:   c = '{3'd6, 6'b111000};
         7'd61:   c = '{3'd5, 6'b100010};
         7'd63:   c = '{3'd6, 6'b001100};
         7'd64:   c = '{3'd6, 6'b011010};
         7'd65:   c = '{3'd2, 6'b010000};
         7'd66:   c = '{3'd4, 6'b100000};
         7'd67:   c = '{3'd4, 6'b101000};
         7'd68:   c = '{3'd3, 6'b100000};
         7'd69:   c = '{3'd1, 6'b000000};
         7'd70:   c = '{3'd4, 6'b001000};
         7'd71:   c = '{3'd3, 6'b110000};
         7'd72:   c = '{3'd4, 6'b000000};
         7'd73:   c = '{3'd2, 6'b000000};
         7'd74:   c = '{3'd4, 6'b011100};
         7'd75:   c = '{3'd3, 6'b101000};
         7'd76:   c = '{3'd4, 6'b010000};
         7'd77:   c = '{3'd2, 6'b110000};
         7'd78:   c = '{3'd2, 6'b100000};
         7'd79:   c = '{3'd3, 6'b111000};
         7'd80:   c = '{3'd4, 6'b011000};
         7'd81:   c = '{3'd4, 6'b110100};
         7'd82:   c = '{3'd3, 6'b010000};
         7'd83:   c = '{3'd3, 6'b000000};
         7'd84:   c = '{3'd1, 6'b100000};
         7'd85:   c = '{3'd3, 6'b001000};
         7'd86:   c = '{3'd4, 6'b000100};
         7'd87:   c = '{3'd3, 6'b011000};
         7'd88:   c = '{3'd4, 6'b100100};
         7'd89:   c = '{3'd4, 6'b101100};
         7'd90:   c = '{3'd4, 6'b110000};
         7'd95:   c = '{3'd6, 6'b001101};
         default: c = '{3'd0, 6'b000000};
      endcase
      return c;
   endfunction

endpackage

/* hdl/mke_front.sv */
// Front end: accepts characters, folds case, looks up the code and queues it.
module mke_front import mke_pkg::*; (
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          push_ready,
   output logic          push_valid,
   output mke_entry_type push_entry
);

   logic [7:0]   folded;
   mke_code_type code;
   logic         in_range;
   logic         is_space;

   always_comb begin
      folded = req_tdata;
      if ((req_tdata >= CHR_LOWER_A) && (req_tdata <= CHR_LOWER_Z)) begin
         folded = req_tdata - CHR_CASE;
      end
   end

   assign in_range = ~req_tdata[7];
   assign is_space = (req_tdata == CHR_SPACE);
   assign code     = mke_lookup(folded[6:0]);

   always_comb begin
      push_entry.is_space = is_space;
      if (is_space) begin
         push_entry.len     = MKE_LEN_W'(1);
         push_entry.pattern = '0;
      end else begin
         push_entry.len     = code.len;
         push_entry.pattern = code.pattern;
      end
   end

   // Characters without a code are consumed and dropped here.
   assign req_tready = push_ready;
   assign push_valid = req_tvalid && in_range && (is_space || (code.len != '0));

endmodule

/* hdl/mke_queue.sv */
// Small first-in first-out queue of classified characters.
module mke_queue import mke_pkg::*; #(
   parameter int DEPTH = MKE_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  mke_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output mke_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mke_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/mke_back.sv */
// Back end: steps through the elements of a queued code and registers each result.
module mke_back import mke_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mke_cfg_type   cfg,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  mke_entry_type pop_entry,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,
   output logic          rsp_tlast
);

   logic                 busy_ff, busy_in;
   logic                 space_ff, space_in;
   logic [MKE_LEN_W-1:0] rem_ff, rem_in;
   logic [5:0]           pat_ff, pat_in;
   logic                 valid_ff, valid_in;
   logic [6:0]           sym_ff, sym_in;
   logic [15:0]          on_ff, on_in;
   logic [15:0]          off_ff, off_in;
   logic [15:0]          freq_ff, freq_in;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic                 emit;
   logic                 elem_last;
   logic                 is_dash;

   assign out_free  = !valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign elem_last = (rem_ff == MKE_LEN_W'(1));
   assign is_dash   = pat_ff[5];
   assign pop_ready = !busy_ff || (emit && elem_last);

   always_comb begin
      busy_in  = busy_ff;
      space_in = space_ff;
      rem_in   = rem_ff;
      pat_in   = pat_ff;
      if (pop_valid && pop_ready) begin
         busy_in  = 1'b1;
         space_in = pop_entry.is_space;
         rem_in   = pop_entry.len;
         pat_in   = pop_entry.pattern;
      end else if (emit) begin
         busy_in = !elem_last;
         rem_in  = rem_ff - MKE_LEN_W'(1);
         pat_in  = {pat_ff[4:0], 1'b0};
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      sym_in   = sym_ff;
      on_in    = on_ff;
      off_in   = off_ff;
      freq_in  = freq_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         last_in  = elem_last;
         on_in    = '0;
         off_in   = '0;
         freq_in  = '0;
         if (space_ff) begin
            sym_in = SYM_SPACE;
            if (cfg.mode == MODE_TONE) begin
               on_in   = cfg.dash_ms;
               off_in  = cfg.end_ms;
               freq_in = SPACE_FREQ_HZ;
            end
         end else begin
            sym_in = is_dash ? SYM_DASH : SYM_DOT;
            if (cfg.mode == MODE_TONE) begin
               on_in   = is_dash ? cfg.dash_ms : cfg.dot_ms;
               off_in  = elem_last ? cfg.end_ms : cfg.gap_ms;
               freq_in = cfg.tone_hz;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      space_ff <= space_in;
      rem_ff   <= rem_in;
      pat_ff   <= pat_in;
      sym_ff   <= sym_in;
      on_ff    <= on_in;
      off_ff   <= off_in;
      freq_ff  <= freq_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, freq_ff, off_ff, on_ff, sym_ff};
   assign rsp_tlast  = last_ff;

endmodule

/* hdl/morse_keyer_encoder.sv */
// Morse keyer encoder top level: configuration registers, front end, queue and back end.
//
// The req channel takes one ASCII character per transaction. Lower case is folded
// to upper case and the character is looked up in the Morse table. Each element
// of its code leaves on the rsp channel as one transaction: symbol, on-time,
// off-time and tone frequency, with tlast on the final element. A space gives a
// single result; unmapped characters and codes 128 and above are consumed and
// give none.
// A character passes through the queue and the back end sequencer before its first
// result is registered in the output register. The back end sequencer emits one
// element per cycle while rsp_tready is high; a code has one to six elements and a
// space has one. A queue of QUEUE_DEPTH looked-up characters separates the two ends,
// so characters keep being accepted while the back end works or the receiver stalls.
// When rsp_tready is low the result holds in the output register and the
// sequencer waits; req_tready drops once the queue is full.
// Reset empties the queue and the output register and restores the default timing
// of 60, 120, 100 and 500 ms at 1000 Hz in tone mode. The csr port writes one register
// per cycle at index csr_index; the user must write it only while idle, which the block does not enforce.
module morse_keyer_encoder import mke_pkg::*; #(
   parameter int QUEUE_DEPTH = MKE_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // char_code
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [55:0]              rsp_tdata,  // symbol, on_ms, off_ms, freq_hz, pad
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [MKE_CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]              csr_wdata
);

   mke_cfg_type   cfg_ff, cfg_in;
   logic          push_valid, push_ready;
   mke_entry_type push_entry;
   logic          pop_valid, pop_ready;
   mke_entry_type pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DOT_MS:      cfg_in.dot_ms  = csr_wdata;
            CSR_DASH_MS:     cfg_in.dash_ms = csr_wdata;
            CSR_GAP_MS:      cfg_in.gap_ms  = csr_wdata;
            CSR_END_MS:      cfg_in.end_ms  = csr_wdata;
            CSR_TONE_HZ:     cfg_in.tone_hz = csr_wdata;
            CSR_OUTPUT_MODE: cfg_in.mode    = mke_mode_type'(csr_wdata[0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_ms  <= RST_DOT_MS;
         cfg_ff.dash_ms <= RST_DASH_MS;
         cfg_ff.gap_ms  <= RST_GAP_MS;
         cfg_ff.end_ms  <= RST_END_MS;
         cfg_ff.tone_hz <= RST_TONE_HZ;
         cfg_ff.mode    <= MODE_TONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mke_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   mke_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   mke_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_text_zero_timing: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (cfg_ff.mode == MODE_TEXT)) |-> (rsp_tdata[54:7] == '0))
      else $error("text mode result carries nonzero timing");

   a_space_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[6:0] == SYM_SPACE)) |-> rsp_tlast)
      else $error("word space result is not marked last");

   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

/* tb/sv/morse_keyer_checker.sv */
// Checker for the Morse keyer encoder: predicts the element stream and compares every result.
module morse_keyer_checker
   import mke_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,  // char_code
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [55:0]              rsp_tdata,  // symbol, on_ms, off_ms, freq_hz, pad
   input  logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [MKE_CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]              csr_wdata,
   output int                       error_count,
   output int                       pending_count,
   output int                       results_checked
);

   typedef struct packed {
      logic [6:0]  symbol;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
      logic [15:0] freq_hz;
      logic        last;
   } morse_element_type;

   morse_element_type elements_due[$];
   mke_cfg_type       timing;

   function automatic string morse_code_of(input logic [7:0] chr);
      case (chr)
         "!":     return "-.-.--";
         "\"":    return ".-..-.";
         "'":     return ".----.";
         "(":     return "-.--.";
         ")":     return "-.--.-";
         ",":     return "--..--";
         "-":     return "-....-";
         ".":     return ".-.-.-";
         "/":     return "-..-.";
         "0":     return "-----";
         "1":     return ".----";
         "2":     return "..---";
         "3":     return "...--";
         "4":     return "....-";
         "5":     return ".....";
         "6":     return "-....";
         "7":     return "--...";
         "8":     return "---..";
         "9":     return "----.";
         ":":     return "---...";
         "=":     return "-...-";
         "?":     return "..--..";
         "@":     return ".--.-.";
         "A":     return ".-";
         "B":     return "-...";
         "C":     return "-.-.";
         "D":     return "-..";
         "E":     return ".";
         "F":     return "..-.";
         "G":     return "--.";
         "H":     return "....";
         "I":     return "..";
         "J":     return ".---";
         "K":     return "-.-";
         "L":     return ".-..";
         "M":     return "--";
         "N":     return "-.";
         "O":     return "---";
         "P":     return ".--.";
         "Q":     return "--.-";
         "R":     return ".-.";
         "S":     return "...";
         "T":     return "-";
         "U":     return "..-";
         "V":     return "...-";
         "W":     return ".--";
         "X":     return "-..-";
         "Y":     return "-.--";
         "Z":     return "--..";
         "_":     return "..--.-";
         default: return "";
      endcase
   endfunction

   // A space is one word-space element; anything without a code adds nothing.
   function automatic void predict_char(input logic [7:0] chr);
      logic [7:0]        upper;
      string             code;
      morse_element_type elem;
      int                j;
      if (chr == CHR_SPACE) begin
         elem = '0;
         elem.symbol = SYM_SPACE;
         elem.last = 1'b1;
         if (timing.mode == MODE_TONE) begin
            elem.on_ms = timing.dash_ms;
            elem.off_ms = timing.end_ms;
            elem.freq_hz = SPACE_FREQ_HZ;
         end
         elements_due.push_back(elem);
         return;
      end
      upper = chr;
      if (chr >= CHR_LOWER_A && chr <= CHR_LOWER_Z) begin
         upper = chr - CHR_CASE;
      end
      code = morse_code_of(upper);
      for (j = 0; j < code.len(); j++) begin
         elem = '0;
         elem.symbol = (code[j] == "-") ? SYM_DASH : SYM_DOT;
         elem.last = (j == code.len() - 1);
         if (timing.mode == MODE_TONE) begin
            elem.on_ms = (code[j] == "-") ? timing.dash_ms : timing.dot_ms;
            elem.off_ms = elem.last ? timing.end_ms : timing.gap_ms;
            elem.freq_hz = timing.tone_hz;
         end
         elements_due.push_back(elem);
      end
   endfunction

   function automatic int field_differs(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      morse_element_type want;
      if (reset) begin
         timing = '{RST_DOT_MS, RST_DASH_MS, RST_GAP_MS, RST_END_MS, RST_TONE_HZ, MODE_TONE};
         elements_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (elements_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = elements_due.pop_front();
               error_count += field_differs("symbol", 16'(want.symbol), 16'(rsp_tdata[6:0]))
                            + field_differs("on_ms", want.on_ms, rsp_tdata[22:7])
                            + field_differs("off_ms", want.off_ms, rsp_tdata[38:23])
                            + field_differs("freq_hz", want.freq_hz, rsp_tdata[54:39])
                            + field_differs("pad", 16'd0, 16'(rsp_tdata[55]))
                            + field_differs("last", 16'(want.last), 16'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_char(req_tdata);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DOT_MS:      timing.dot_ms = csr_wdata;
               CSR_DASH_MS:     timing.dash_ms = csr_wdata;
               CSR_GAP_MS:      timing.gap_ms = csr_wdata;
               CSR_END_MS:      timing.end_ms = csr_wdata;
               CSR_TONE_HZ:     timing.tone_hz = csr_wdata;
               CSR_OUTPUT_MODE: timing.mode = mke_mode_type'(csr_wdata[0]);
               default: ;
            endcase
         end
      end
      pending_count = elements_due.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the Morse keyer encoder testbench: clock, reset, stimulus, pacing and verdict.
module testbench;
   import mke_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 50;

   localparam logic [MKE_CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [MKE_CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam string CODED_CHARS =
      "!\"'(),-./0123456789:=?@ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz";

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [55:0]              rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we = 1'b0;
   logic [MKE_CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]              csr_wdata = '0;

   int error_count;
   int pending_count;
   int results_checked;
   int quiet_cycles = 0;
   int burst_left = 0;
   int chars_sent = 0;
   int settings_used = 1;
   bit hold_wanted = 1'b0;
   bit hold_served = 1'b0;

   morse_keyer_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   morse_keyer_checker element_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results still due",
                  $time, quiet_cycles, pending_count);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver switches between pacing patterns and serves one long hold-off on request.
   initial begin : rsp_pacing
      int pattern;
      int span;
      int k;
      forever begin
         if (hold_wanted && !hold_served) begin
            repeat (HOLD_CYCLES) @(negedge clock) rsp_tready <= 1'b0;
            hold_served = 1'b1;
         end else begin
            pattern = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            for (k = 0; k < span; k++) begin
               @(negedge clock);
               case (pattern)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= $urandom_range(0, 1);
                  2:       rsp_tready <= (k % 4 == 3);
                  default: rsp_tready <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   task automatic send_char(input logic [7:0] chr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= chr;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      chars_sent++;
   endtask

   task automatic send_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         send_char(text[i]);
      end
   endtask

   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         return CHR_SPACE;
      end else if (roll < 70) begin
         return CODED_CHARS[$urandom_range(0, CODED_CHARS.len() - 1)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Stop offering, wait for every expected result, then let unmapped characters drain.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [MKE_CSR_IDX_W-1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_settings(input logic [15:0] dot, input logic [15:0] dash,
                                input logic [15:0] gap, input logic [15:0] tail,
                                input logic [15:0] tone, input mke_mode_type mode);
      logic [15:0] mode_word;
      mode_word = 16'($urandom);
      mode_word[0] = mode;
      write_reg(CSR_DOT_MS, dot);
      write_reg(CSR_DASH_MS, dash);
      write_reg(CSR_GAP_MS, gap);
      write_reg(CSR_END_MS, tail);
      write_reg(CSR_TONE_HZ, tone);
      write_reg(CSR_OUTPUT_MODE, mode_word);
      write_reg(CSR_SPARE_LO, 16'($urandom));
      write_reg(CSR_SPARE_HI, 16'($urandom));
      settings_used++;
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      send_text("Aa zE0T5!_,?@");
      send_char(8'h00);
      send_char(8'h7F);
      send_char(8'h80);
      send_char(8'hFF);
      send_char("#");
      drain();
      write_reg(CSR_OUTPUT_MODE, 16'(MODE_TEXT));
      settings_used++;
      send_text(" Aq");
      send_char(8'hFF);
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_settings('0, '0, '0, '0, '0, MODE_TONE);
            1: load_settings('1, '1, '1, '1, '1, MODE_TONE);
            2: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), MODE_TEXT);
            default: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom),
                                   mke_mode_type'($urandom_range(0, 1)));
         endcase
         if (phase == 4) begin
            hold_wanted = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_char(pick_char());
         end
         drain();
      end

      $display("Run covered %0d characters under %0d register settings in tone and text mode,",
               chars_sent, settings_used);
      $display("with a long receiver hold-off; %0d results were compared.", results_checked);
      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
